/* rtl/gww_pkg.sv */
// Shared types, constants and helpers for the greedy word wrap block.
package gww_pkg;

  localparam int CHAR_W = 8;
  localparam int CFG_W  = 6;

  localparam logic [CFG_W-1:0]  CFG_WIDTH_RESET = 6'd32;

  localparam logic [CHAR_W-1:0] CH_LOW_A  = 8'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CH_LOW_Z  = 8'h7A;  // 'z'
  localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;  // 'A'
  localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;  // 'Z'
  localparam logic [CHAR_W-1:0] CH_DIG_0  = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CH_DIG_9  = 8'h39;  // '9'
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_NONE   = 8'h00;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PREFIX = 6'b000010,
    S_RD     = 6'b000100,
    S_CHR    = 6'b001000,
    S_NL     = 6'b010000,
    S_ERR    = 6'b100000
  } gww_state_t;

  function automatic logic is_word_byte(input logic [CHAR_W-1:0] c);
    return ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) ||
           ((c >= CH_UP_A)  && (c <= CH_UP_Z))  ||
           ((c >= CH_DIG_0) && (c <= CH_DIG_9));
  endfunction

endpackage

/* rtl/gww_in_if.sv */
// Input channel: one text byte or a paragraph end per beat.
interface gww_in_if;
  logic                      valid;
  logic                      ready;
  logic [gww_pkg::CHAR_W-1:0] ch;
  logic                      para_end;

  modport source (output valid, output ch, output para_end, input ready);
  modport sink   (input valid, input ch, input para_end, output ready);
endinterface

/* rtl/gww_out_if.sv */
// Result channel: one wrapped output byte or an error per beat.
interface gww_out_if;
  logic                      valid;
  logic                      ready;
  logic [gww_pkg::CHAR_W-1:0] out_char;
  logic                      is_error;
  logic                      last;

  modport source (output valid, output out_char, output is_error, output last, input ready);
  modport sink   (input valid, input out_char, input is_error, input last, output ready);
endinterface

/* rtl/gww_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module gww_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* rtl/greedy_word_wrap_unit.sv */
// Greedy word wrap: buffers words of a byte stream and emits wrapped lines.
//
// Bytes arrive one per input beat. Letters and digits are written into a
// word RAM (MAX_WIDTH bytes) and produce no result of their own.
// Any other byte ends the pending word; at that point, or at a paragraph
// end, the word is placed on the current line after one space, or after a
// newline if it would not fit within the configured width. Placing a word
// streams each character as a RAM read followed by a load of the output
// register, after the separating space or newline (none on an empty line)
// and followed by a final newline at paragraph end.
// The input is accepted only while no word is being streamed out, which
// also keeps RAM writes and reads from ever touching the same entry at
// once. Results leave through a one-entry output register, so the block
// returns to accepting input while the last result of an item still waits.
// A word longer than the width yields one error beat (out_char 0, is_error
// and last set) and the rest of the paragraph is dropped. line_width is
// taken as 1 when written 0 and as MAX_WIDTH when above it; write it only
// while the block is idle.
module greedy_word_wrap_unit #(
  parameter int MAX_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  gww_in_if.sink                    in_chan,
  gww_out_if.source                 out_chan,
  input  logic                      cfg_we,
  input  logic [gww_pkg::CFG_W-1:0] cfg_wdata
);
  import gww_pkg::*;

  localparam int LEN_W  = $clog2(MAX_WIDTH + 1);
  localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int SUM_W  = LEN_W + 2;

  gww_state_t        state_r, state_nxt;
  logic [CFG_W-1:0]  cfg_width_r;
  logic [LEN_W-1:0]  wl_r, wl_nxt;      // pending word length
  logic [LEN_W-1:0]  ll_r, ll_nxt;      // characters on current line
  logic [LEN_W-1:0]  idx_r, idx_nxt;    // streaming index into word RAM
  logic              disc_r, disc_nxt;  // dropping rest of paragraph
  logic              pend_r, pend_nxt;  // final newline follows the word
  logic [CHAR_W-1:0] prefix_r, prefix_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_err_r, out_err_nxt;
  logic              out_last_r, out_last_nxt;

  logic [LEN_W-1:0]  eff_w;
  logic              slot_free;
  logic              in_fire;
  logic              ram_we, ram_re;
  logic [CHAR_W-1:0] ram_rdata;
  logic              fits_space;
  logic              last_chr;

  // Effective width, clamped to 1..MAX_WIDTH.
  always_comb begin
    if (cfg_width_r == '0) begin
      eff_w = LEN_W'(1);
    end else if ({1'b0, cfg_width_r} > (CFG_W + 1)'(MAX_WIDTH)) begin
      eff_w = LEN_W'(MAX_WIDTH);
    end else begin
      eff_w = cfg_width_r[LEN_W-1:0];
    end
  end

  assign slot_free  = !out_valid_r || out_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire    = in_chan.valid && in_chan.ready;
  assign fits_space = (SUM_W'(ll_r) + SUM_W'(1) + SUM_W'(wl_r)) <= SUM_W'(eff_w);
  assign last_chr   = (idx_r == (wl_r - LEN_W'(1)));

  // Letters and digits go to the RAM at the current word length.
  assign ram_we = in_fire && !in_chan.para_end && !disc_r &&
                  is_word_byte(in_chan.ch) && (wl_r < eff_w);
  assign ram_re = (state_r == S_RD);

  gww_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_WIDTH)
  ) u_word_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wl_r[ADDR_W-1:0]),
    .wdata (in_chan.ch),
    .re    (ram_re),
    .raddr (idx_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    wl_nxt        = wl_r;
    ll_nxt        = ll_r;
    idx_nxt       = idx_r;
    disc_nxt      = disc_r;
    pend_nxt      = pend_r;
    prefix_nxt    = prefix_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_char_nxt  = out_char_r;
    out_err_nxt   = out_err_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          idx_nxt = '0;
          if (in_chan.para_end && disc_r) begin
            // paragraph end while dropping: silent return to idle
            disc_nxt = 1'b0;
            wl_nxt   = '0;
            ll_nxt   = '0;
          end else if (in_chan.para_end || (!disc_r && !is_word_byte(in_chan.ch))) begin
            // word boundary: place the pending word
            pend_nxt = in_chan.para_end;
            if (wl_r == '0) begin
              if (in_chan.para_end) begin
                state_nxt = S_NL;
                ll_nxt    = '0;
              end
            end else if (wl_r > eff_w) begin
              // width lowered under a pending word
              state_nxt = S_ERR;
              wl_nxt    = '0;
              if (in_chan.para_end) begin
                ll_nxt = '0;
              end else begin
                disc_nxt = 1'b1;
              end
            end else if (ll_r == '0) begin
              state_nxt = S_RD;
              ll_nxt    = wl_r;
            end else if (fits_space) begin
              state_nxt  = S_PREFIX;
              prefix_nxt = CH_SPACE;
              ll_nxt     = ll_r + LEN_W'(1) + wl_r;
            end else begin
              state_nxt  = S_PREFIX;
              prefix_nxt = CH_NL;
              ll_nxt     = wl_r;
            end
            if (in_chan.para_end && (wl_r != '0) && (wl_r <= eff_w)) begin
              ll_nxt = '0;
            end
          end else if (!disc_r) begin
            // word byte
            if (wl_r >= eff_w) begin
              state_nxt = S_ERR;
              wl_nxt    = '0;
              disc_nxt  = 1'b1;
            end else begin
              wl_nxt = wl_r + LEN_W'(1);
            end
          end
        end
      end
      S_PREFIX: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = prefix_r;
          out_err_nxt   = 1'b0;
          out_last_nxt  = 1'b0;
          state_nxt     = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_CHR;
      end
      S_CHR: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ram_rdata;
          out_err_nxt   = 1'b0;
          out_last_nxt  = last_chr && !pend_r;
          if (last_chr) begin
            wl_nxt    = '0;
            state_nxt = pend_r ? S_NL : S_IDLE;
          end else begin
            idx_nxt   = idx_r + LEN_W'(1);
            state_nxt = S_RD;
          end
        end
      end
      S_NL: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_NL;
          out_err_nxt   = 1'b0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_ERR: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_NONE;
          out_err_nxt   = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_width_r <= CFG_WIDTH_RESET;
      wl_r        <= '0;
      ll_r        <= '0;
      disc_r      <= 1'b0;
      pend_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wl_r        <= wl_nxt;
      ll_r        <= ll_nxt;
      disc_r      <= disc_nxt;
      pend_r      <= pend_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_width_r <= cfg_wdata;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    prefix_r   <= prefix_nxt;
    out_char_r <= out_char_nxt;
    out_err_r  <= out_err_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.out_char = out_char_r;
  assign out_chan.is_error = out_err_r;
  assign out_chan.last     = out_last_r;

  // An error beat is always the only and final beat of its item.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.is_error |-> out_chan.last && (out_chan.out_char == CH_NONE))
    else $error("error beat without last or with nonzero char");

  // While dropping a paragraph no word is held.
  a_disc_empty: assert property (@(posedge clk) disable iff (!rst_n)
    disc_r |-> (wl_r == '0))
    else $error("word pending while discarding");

  // Lengths never pass the largest width.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (wl_r <= LEN_W'(MAX_WIDTH)) && (ll_r <= LEN_W'(MAX_WIDTH)))
    else $error("length above MAX_WIDTH");

  // A RAM read is always followed by the cycle that consumes it.
  a_rd_chr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |=> (state_r == S_CHR))
    else $error("word RAM read not consumed");

  // Streaming index stays inside the pending word.
  a_idx_in_word: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHR) |-> (idx_r < wl_r))
    else $error("streaming index past word end");
endmodule

/* bench/gww_wrap_checker.sv */
`timescale 1ns / 1ps
// Checker for the word wrap block: predicts result beats from accepted input and compares them.
module gww_wrap_checker #(
  parameter int MAX_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  gww_in_if                         in_mon,
  gww_out_if                        out_mon,
  input  logic                      cfg_we,
  input  logic [gww_pkg::CFG_W-1:0] cfg_wdata,
  output int                        fail_count,
  output int                        open_count
);
  import gww_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              err;
    logic              last;
  } wrap_beat_t;

  // shadow state of the block
  logic [CHAR_W-1:0] word_buf [MAX_WIDTH];
  int                word_len;
  int                line_len;
  bit                dropping;
  logic [CFG_W-1:0]  width_reg;

  wrap_beat_t        wrapped_q[$];   // expected beats, oldest first
  wrap_beat_t        step_q[$];      // beats of the item being predicted
  int                fails;

  function automatic int cap_width();
    int w;
    w = int'(width_reg);
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic bit alnum(input logic [CHAR_W-1:0] c);
    return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
           (c >= CH_DIG_0 && c <= CH_DIG_9);
  endfunction

  task automatic push_beat(input logic [CHAR_W-1:0] c, input logic e);
    wrap_beat_t b;
    b.ch   = c;
    b.err  = e;
    b.last = 1'b0;
    step_q.push_back(b);
  endtask

  // put the pending word on the line; ok=0 when it no longer fits the width
  task automatic place_word(output bit ok);
    int w;
    w  = cap_width();
    ok = 1'b1;
    if (word_len == 0) return;
    if (word_len > w) begin
      push_beat(CH_NONE, 1'b1);
      word_len = 0;
      ok = 1'b0;
      return;
    end
    if (line_len != 0) begin
      if (line_len + 1 + word_len <= w) begin
        push_beat(CH_SPACE, 1'b0);
        line_len += 1;
      end else begin
        push_beat(CH_NL, 1'b0);
        line_len = 0;
      end
    end
    for (int i = 0; i < word_len; i++) push_beat(word_buf[i], 1'b0);
    line_len = (line_len + word_len) & 63;
    word_len = 0;
  endtask

  task automatic wrap_step(input logic [CHAR_W-1:0] c, input logic pe);
    bit         ok;
    wrap_beat_t b;
    step_q.delete();
    if (pe) begin
      if (dropping) begin
        dropping = 1'b0;
      end else begin
        place_word(ok);
        if (ok) push_beat(CH_NL, 1'b0);
      end
      word_len = 0;
      line_len = 0;
    end else if (!dropping) begin
      if (alnum(c)) begin
        if (word_len >= cap_width()) begin
          push_beat(CH_NONE, 1'b1);
          word_len = 0;
          dropping = 1'b1;
        end else begin
          word_buf[word_len] = c;
          word_len++;
        end
      end else begin
        place_word(ok);
        if (!ok) dropping = 1'b1;
      end
    end
    for (int i = 0; i < step_q.size(); i++) begin
      b      = step_q[i];
      b.last = (i == step_q.size() - 1);
      wrapped_q.push_back(b);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    fails++;
  endtask

  initial fails = 0;

  always @(posedge clk) begin
    wrap_beat_t exp_b;
    if (!rst_n) begin
      word_len  = 0;
      line_len  = 0;
      dropping  = 1'b0;
      width_reg = CFG_WIDTH_RESET;
      wrapped_q.delete();
    end else begin
      // result side first: a beat leaving now came from an earlier input
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        if (wrapped_q.size() == 0) begin
          report_mismatch($sformatf("result beat with none expected (char %h err %b last %b)",
                                    out_mon.out_char, out_mon.is_error, out_mon.last));
        end else begin
          exp_b = wrapped_q.pop_front();
          if (out_mon.out_char !== exp_b.ch)
            report_mismatch($sformatf("out_char %h, expected %h", out_mon.out_char, exp_b.ch));
          if (out_mon.is_error !== exp_b.err)
            report_mismatch($sformatf("is_error %b, expected %b", out_mon.is_error, exp_b.err));
          if (out_mon.last !== exp_b.last)
            report_mismatch($sformatf("last %b, expected %b", out_mon.last, exp_b.last));
        end
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1)
        wrap_step(in_mon.ch, in_mon.para_end);
      if (cfg_we === 1'b1) width_reg = cfg_wdata;
    end
    fail_count <= fails;
    open_count <= wrapped_q.size();
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top for the greedy word wrap unit: stimulus, handshake pressure and verdict.
module tb_top;
  import gww_pkg::*;

  localparam int IDLE_PCT      = 28;   // chance per cycle that a side idles
  localparam int HOLD_CYCLES   = 400;  // long receiver hold-off
  localparam int SETTLE_CYCLES = 100;  // extra pause after every expected beat is seen
  localparam int RAND_ITEMS    = 250;  // directed beats and last-phase overrun fill up the rest

  // width per random phase; the extremes come early, random after the list
  localparam int N_PICKS = 10;
  localparam int WIDTH_PICKS [N_PICKS] = '{63, 1, 20, 3, 32, 8, 33, 12, 2, 31};

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  int               fail_count;
  int               open_count;   // expected beats not yet seen

  bit               hold_go;      // asks the receiver for one long hold-off
  bit               calm;         // no idling on either side while set
  int               beats_sent;
  int               cur_w;        // effective width, used to size words

  gww_in_if  in_bus ();
  gww_out_if out_bus ();

  greedy_word_wrap_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_bus),
    .out_chan  (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  gww_wrap_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop; the slowest legal run is far below this
  initial begin
    #8_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: random ready, plus one long hold-off on request. The hold-off
  // is counted here so the sender keeps offering beats meanwhile.
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // One input beat. Valid may drop for random idle cycles first; once raised
  // it stays up until the block takes the beat.
  task automatic send_beat(input logic [CHAR_W-1:0] c, input logic pe);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid    <= 1'b1;
    in_bus.ch       <= c;
    in_bus.para_end <= pe;
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  // Sender pause: wait for every expected beat, then for any word still being
  // buffered or streamed (letters alone leave nothing expected).
  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called while the block is idle
  task automatic set_width(input int v);
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_w = (v < 1) ? 1 : ((v > 32) ? 32 : v);
  endtask

  function automatic logic [CHAR_W-1:0] rand_word_byte();
    case ($urandom_range(2))
      0:       return CHAR_W'(CH_LOW_A + $urandom_range(25));
      1:       return CHAR_W'(CH_UP_A + $urandom_range(25));
      default: return CHAR_W'(CH_DIG_0 + $urandom_range(9));
    endcase
  endfunction

  // any non-alphanumeric byte; alphanumerics all sit below 0x80
  function automatic logic [CHAR_W-1:0] rand_sep_byte();
    logic [CHAR_W-1:0] c;
    c = CHAR_W'($urandom_range(255));
    if (is_word_byte(c)) c = c ^ 8'h80;
    return c;
  endfunction

  // A paragraph of random words. Mostly words that fit, some exactly at the
  // width, a few too long; separator runs and raw noise now and then. An
  // unfinished paragraph carries its line (and maybe a word) into the next
  // phase, where the width may have changed.
  task automatic send_para(input bit finish);
    int n_words;
    int len;
    int r;
    int n_sep;
    n_words = 1 + $urandom_range(7);
    if ($urandom_range(9) == 0) send_beat(rand_sep_byte(), 1'b0);
    for (int k = 0; k < n_words; k++) begin
      r = $urandom_range(99);
      if (r < 6)       len = cur_w + 1 + $urandom_range(2);
      else if (r < 15) len = cur_w;
      else             len = 1 + $urandom_range(((cur_w < 6) ? cur_w : 6) - 1);
      for (int j = 0; j < len; j++) send_beat(rand_word_byte(), 1'b0);
      if (k < n_words - 1 || $urandom_range(1)) begin
        n_sep = ($urandom_range(9) == 0) ? 2 + $urandom_range(2) : 1;
        repeat (n_sep) send_beat(rand_sep_byte(), 1'b0);
      end
      if ($urandom_range(19) == 0)
        repeat (1 + $urandom_range(5)) send_beat(CHAR_W'($urandom_range(255)), 1'b0);
    end
    if (finish) send_beat(CHAR_W'($urandom_range(255)), 1'b1);
  endtask

  initial begin
    int rand_end;
    int phase;
    int n_par;
    int v;

    in_bus.valid    <= 1'b0;
    in_bus.ch       <= '0;
    in_bus.para_end <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    rst_n           <= 1'b0;
    hold_go    = 1'b0;
    calm       = 1'b0;
    beats_sent = 0;
    cur_w      = 32;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part, reset width 32 ---
    send_beat(8'hFF, 1'b1);            // empty paragraph: newline only
    send_beat(8'h00, 1'b0);            // leading separator
    send_text("az/AZ@[09:{");          // class edges and their neighbors
    send_beat(8'h00, 1'b1);

    // word grows past the width: one error, rest dropped up to the end
    drain();
    set_width(2);
    send_text("abcx");
    send_beat(8'h00, 1'b1);

    // width lowered under a buffered word, placed by a separator
    drain();
    set_width(5);
    send_text("abcd");
    drain();
    set_width(2);
    send_beat(CH_SPACE, 1'b0);
    send_beat(8'h00, 1'b1);

    // width lowered under a buffered word, placed by the paragraph end;
    // zero acts as one
    drain();
    set_width(5);
    send_text("abc");
    drain();
    set_width(0);
    send_beat(8'h00, 1'b1);

    // --- random phases, width changes only between them ---
    rand_end = beats_sent + RAND_ITEMS;
    phase    = 0;
    while (beats_sent < rand_end) begin
      drain();
      v = (phase < N_PICKS) ? WIDTH_PICKS[phase] : $urandom_range(63);
      set_width(v);
      if (phase == 2) hold_go = 1'b1;   // block fills and stalls its input
      calm  = (phase == 0);
      n_par = 1 + $urandom_range(2);
      for (int p = 0; p < n_par; p++)
        send_para((p < n_par - 1) || ($urandom_range(99) < 60));
      phase++;
    end
    calm = 1'b0;
    drain();

    if (fail_count == 0 && open_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
